// File: sv/lookup2_byte_hash_assert.svh
// Assertion macros shared by the lookup2 byte hash RTL.
`ifndef LOOKUP2_BYTE_HASH_ASSERT_SVH
`define LOOKUP2_BYTE_HASH_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LBH_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lbh_pkg.sv
// Types, constants and mix functions for the lookup2 byte hash.
`default_nettype none

package lbh_pkg;

  // Initial value of words a and b.
  localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

  // Bytes in one block and the fill count that marks a full block.
  localparam int          BLOCK_BYTES = 12;
  localparam logic [3:0]  FULL_FILL   = 4'(BLOCK_BYTES);

  // One line of the mix per pipeline stage.
  localparam int MIX_STEPS = 9;

  typedef logic [BLOCK_BYTES-1:0][7:0] blk_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // Sideband that travels with a request through the block mix.
  typedef struct packed {
    logic        fin;    // request closes a message
    logic        dabs;   // request absorbs a full block
    logic        fresh;  // no block absorbed yet in this message
    logic [31:0] seed;   // seed of the message
    words_t      tail;   // tail bytes and length added before the final mix
  } side_t;

  // Word-wise 32-bit wrapping add.
  function automatic words_t add_words(input words_t x, input words_t y);
    words_t r;
    r.a = x.a + y.a;
    r.b = x.b + y.b;
    r.c = x.c + y.c;
    return r;
  endfunction

  // One of the nine lines of the lookup2 mix.
  function automatic words_t mix_line(input logic [3:0] step, input words_t w);
    words_t r;
    r = w;
    case (step)
      4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/lbh_if.sv
// Request channel interfaces of the lookup2 byte hash.
`default_nettype none

// Byte channel into the hash.
interface lbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

// Hash result channel.
interface lbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// File: sv/lbh_mix_pipe.sv
// Nine-stage pipeline that runs the lookup2 mix, one mix line per stage.
`default_nettype none

module lbh_mix_pipe #(
  parameter int SIDE_W = 1
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  wire                 in_valid,
  input  lbh_pkg::words_t     in_words,
  input  wire  [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output lbh_pkg::words_t     out_words,
  output logic [SIDE_W-1:0]   out_side
);

  logic [lbh_pkg::MIX_STEPS-1:0] vld_r;
  lbh_pkg::words_t               wrd_r  [lbh_pkg::MIX_STEPS];
  logic [SIDE_W-1:0]             side_r [lbh_pkg::MIX_STEPS];

  // Stage valid bits shift along whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[lbh_pkg::MIX_STEPS-2:0], in_valid};
    end
  end

  // Each stage applies its own mix line to the words of the stage before.
  always_ff @(posedge clk) begin
    if (adv) begin
      wrd_r[0]  <= lbh_pkg::mix_line(4'd0, in_words);
      side_r[0] <= in_side;
      for (int i = 1; i < lbh_pkg::MIX_STEPS; i++) begin
        wrd_r[i]  <= lbh_pkg::mix_line(4'(i), wrd_r[i-1]);
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[lbh_pkg::MIX_STEPS-1];
  assign out_words = wrd_r[lbh_pkg::MIX_STEPS-1];
  assign out_side  = side_r[lbh_pkg::MIX_STEPS-1];

endmodule

`default_nettype wire

// File: sv/lbh_collect.sv
// Byte collector: packs bytes into 12-byte blocks and issues mix requests.
`default_nettype none

module lbh_collect (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  wire  [31:0]      seed,
  input  lbh_pkg::words_t  state,
  lbh_in_if.sink           in_chan,
  output logic             e_valid,
  output lbh_pkg::words_t  e_words,
  output lbh_pkg::side_t   e_side
);

  logic            active_r;
  logic            fresh_r;
  logic [3:0]      fill_r;
  logic [31:0]     count_r;
  logic [31:0]     seed_r;
  lbh_pkg::blk_t   buf_r;

  logic            go;
  logic            absorb_now;
  logic            fr;
  logic [3:0]      f;
  logic [3:0]      nfill;
  logic [31:0]     cnt;
  logic [31:0]     ncnt;
  logic [31:0]     sd;
  logic            dabs;
  lbh_pkg::blk_t   cur;
  lbh_pkg::blk_t   nbuf;
  lbh_pkg::blk_t   blk;
  lbh_pkg::words_t blk_words;
  lbh_pkg::words_t tail_words;
  lbh_pkg::words_t base;

  assign in_chan.ready = adv;

  // An item with neither a byte nor an end mark does nothing.
  assign go = in_chan.valid && adv && (in_chan.has_byte || in_chan.last);

  // Next buffer, fill and count; a closed message reads as a fresh one.
  always_comb begin
    f          = active_r ? fill_r  : 4'd0;
    fr         = active_r ? fresh_r : 1'b1;
    cnt        = active_r ? count_r : 32'd0;
    sd         = active_r ? seed_r  : seed;
    cur        = active_r ? buf_r   : '0;
    absorb_now = in_chan.has_byte && (f == lbh_pkg::FULL_FILL);
    nbuf       = absorb_now ? '0 : cur;
    for (int i = 0; i < lbh_pkg::BLOCK_BYTES; i++) begin
      if (in_chan.has_byte && ((absorb_now && i == 0) || (!absorb_now && f == 4'(i)))) begin
        nbuf[i] = in_chan.data_byte;
      end
    end
    if (!in_chan.has_byte) begin
      nfill = f;
    end else if (absorb_now) begin
      nfill = 4'd1;
    end else begin
      nfill = f + 4'd1;
    end
    ncnt = cnt + 32'(in_chan.has_byte);
  end

  // Request contents: a block to absorb, the tail with the length, the base words.
  always_comb begin
    dabs        = absorb_now || (in_chan.last && nfill == lbh_pkg::FULL_FILL);
    blk         = absorb_now ? cur : nbuf;
    blk_words.a = blk[3:0];
    blk_words.b = blk[7:4];
    blk_words.c = blk[11:8];
    if (nfill == lbh_pkg::FULL_FILL) begin
      tail_words.a = 32'd0;
      tail_words.b = 32'd0;
      tail_words.c = ncnt;
    end else begin
      tail_words.a = nbuf[3:0];
      tail_words.b = nbuf[7:4];
      tail_words.c = {nbuf[10:8], 8'h00} + ncnt;
    end
    if (fr) begin
      base.a = lbh_pkg::GOLDEN_WORD;
      base.b = lbh_pkg::GOLDEN_WORD;
      base.c = sd;
    end else begin
      base = state;
    end
  end

  // Message state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fresh_r  <= 1'b1;
      fill_r   <= 4'd0;
      count_r  <= 32'd0;
    end else if (go) begin
      active_r <= !in_chan.last;
      fresh_r  <= fr && !absorb_now;
      fill_r   <= nfill;
      count_r  <= ncnt;
    end
  end

  // Byte buffer and message seed.
  always_ff @(posedge clk) begin
    if (go) begin
      buf_r  <= nbuf;
      seed_r <= sd;
    end
  end

  // Entry register in front of the block mix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= go && (absorb_now || in_chan.last);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_words      <= lbh_pkg::add_words(base, blk_words);
      e_side.fin   <= in_chan.last;
      e_side.dabs  <= dabs;
      e_side.fresh <= fr;
      e_side.seed  <= sd;
      e_side.tail  <= tail_words;
    end
  end

endmodule

`default_nettype wire

// File: sv/lookup2_byte_hash.sv
// Lookup2 32-bit hash over a byte stream, fully pipelined.
//
// in_chan carries one byte per request (data_byte, has_byte, last). A request
// with last set closes the message; has_byte clear with last set closes it
// without a byte (an empty message if nothing came before). A request with
// neither flag is dropped. out_chan carries one hash_value per message.
// cfg_we/cfg_wdata write the seed; it takes effect at the next message start.
//
// One request is taken every cycle while the pipeline does not hold. For a
// request that closes a message, the entry register loads at the accepting
// edge, then nine block-mix stages and nine final-mix stages follow (tail and
// length are added in front of the first final-mix stage), and last comes
// the result register. Full blocks run through the block mix once per 12 bytes.
//
// Synchronous reset clears the pipeline, the open message and the seed to 0.
// While a result waits in the output register, requests are still taken; the
// whole pipeline holds (and in_chan.ready drops) only when another result
// reaches the end of the final mix before the waiting one has been taken.
`default_nettype none

module lookup2_byte_hash (
  input  wire          clk,
  input  wire          rst_n,
  lbh_in_if.sink       in_chan,
  lbh_out_if.source    out_chan,
  input  wire          cfg_we,
  input  wire  [31:0]  cfg_wdata
);

  `include "lookup2_byte_hash_assert.svh"

  localparam int SIDE_W = $bits(lbh_pkg::side_t);

  logic                 adv;
  logic                 stall;
  logic [31:0]          seed_r;
  lbh_pkg::words_t      state_r;

  logic                 e_valid;
  lbh_pkg::words_t      e_words;
  lbh_pkg::side_t       e_side;

  logic                 m_valid;
  lbh_pkg::words_t      m_words;
  logic [SIDE_W-1:0]    m_side_raw;
  lbh_pkg::side_t       m_side;

  lbh_pkg::words_t      pre;
  lbh_pkg::words_t      j_words;

  logic                 n_valid;
  lbh_pkg::words_t      n_words;

  logic                 out_valid_r;
  logic [31:0]          hash_r;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // The pipeline holds only when a new result would overwrite a waiting one.
  assign stall = out_valid_r && !out_chan.ready && n_valid;
  assign adv   = !stall;

  lbh_collect u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .seed    (seed_r),
    .state   (state_r),
    .in_chan (in_chan),
    .e_valid (e_valid),
    .e_words (e_words),
    .e_side  (e_side)
  );

  lbh_mix_pipe #(
    .SIDE_W (SIDE_W)
  ) u_block_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (e_valid),
    .in_words  (e_words),
    .in_side   (e_side),
    .out_valid (m_valid),
    .out_words (m_words),
    .out_side  (m_side_raw)
  );

  assign m_side = lbh_pkg::side_t'(m_side_raw);

  // Junction: pick the absorbed block or the running words, then add the tail.
  always_comb begin
    if (m_side.dabs) begin
      pre = m_words;
    end else if (m_side.fresh) begin
      pre.a = lbh_pkg::GOLDEN_WORD;
      pre.b = lbh_pkg::GOLDEN_WORD;
      pre.c = m_side.seed;
    end else begin
      pre = state_r;
    end
    j_words = lbh_pkg::add_words(pre, m_side.tail);
  end

  // Running words of the open message, updated after each absorbed block.
  always_ff @(posedge clk) begin
    if (adv && m_valid && m_side.dabs) begin
      state_r <= m_words;
    end
  end

  lbh_mix_pipe #(
    .SIDE_W (1)
  ) u_final_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (m_valid && m_side.fin),
    .in_words  (j_words),
    .in_side   (1'b0),
    .out_valid (n_valid),
    .out_words (n_words),
    .out_side  ()
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= n_valid || (out_valid_r && !out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && n_valid) begin
      hash_r <= n_words.c;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = hash_r;

  // Checks on the stall and result register logic.
  `LBH_ASSERT_HOLDS(a_ready_low_only_on_stall, !in_chan.ready,
    out_chan.valid && !out_chan.ready, "input held back without a stalled result")
  `LBH_ASSERT_NEXT(a_stall_keeps_results, stall, n_valid && out_chan.valid,
    "result lost during a stall")
  `LBH_ASSERT_NEXT(a_taken_result_clears, out_chan.valid && out_chan.ready && !n_valid,
    !out_chan.valid, "result repeated after it was taken")

endmodule

`default_nettype wire
